// File: rtl/mmsm_pkg.sv
`default_nettype none

package mmsm_pkg;

    localparam int NUM_MARKERS    = 7;
    localparam int MAX_MARKER_LEN = 32;
    localparam int FIXED_MARKERS  = 7;
    localparam int PROG_W         = $clog2(MAX_MARKER_LEN);
    localparam int HIT_W          = 7;
    localparam int STR_W          = 8 * MAX_MARKER_LEN;

    typedef logic [MAX_MARKER_LEN-1:0][7:0] row_t;
    typedef logic [PROG_W-1:0]              prog_t;
    typedef logic [HIT_W-1:0]               hit_t;

    // one item as it moves down the chain
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       eop;
        hit_t       mask;
    } stage_t;

    // raw marker text, right justified (last character in the low byte)
    function automatic logic [STR_W-1:0] marker_text(input int k);
        logic [STR_W-1:0] s;
        s = '0;
        unique case (k)
            0:       s = STR_W'("phase5d-ok");
            1:       s = STR_W'("utest.bin");
            2:       s = STR_W'("Saved: /term5d.txt");
            3:       s = STR_W'("stream-output-ok");
            4:       s = STR_W'("argv[1]=child-output-ok");
            5:       s = STR_W'("Press one key to return:");
            6:       s = STR_W'("You chose: x");
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic int marker_raw_len(input int k);
        int n;
        n = 0;
        unique case (k)
            0:       n = 10;
            1:       n = 9;
            2:       n = 18;
            3:       n = 16;
            4:       n = 23;
            5:       n = 24;
            6:       n = 12;
            default: n = 0;
        endcase
        return n;
    endfunction

    // strings over MAX_MARKER_LEN - 1 characters are cut to that length
    function automatic int marker_len(input int k);
        int n;
        n = marker_raw_len(k);
        if (k >= FIXED_MARKERS) begin
            n = 0;
        end
        if (n > MAX_MARKER_LEN - 1) begin
            n = MAX_MARKER_LEN - 1;
        end
        return n;
    endfunction

    // row of characters, first character at index 0, zero padded
    function automatic row_t marker_row(input int k);
        row_t             r;
        logic [STR_W-1:0] s;
        int               raw;
        int               n;
        r   = '0;
        s   = marker_text(k);
        raw = marker_raw_len(k);
        n   = marker_len(k);
        for (int i = 0; i < MAX_MARKER_LEN; i++) begin
            if (i < n) begin
                r[i] = s[(raw - 1 - i) * 8 +: 8];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mmsm_cell.sv
`default_nettype none

module mmsm_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire mmsm_pkg::row_t  pattern,
    input  wire mmsm_pkg::prog_t len,
    input  wire mmsm_pkg::hit_t  hit_bit,
    input  wire mmsm_pkg::stage_t stage_in,
    output mmsm_pkg::stage_t     stage_out,
    output mmsm_pkg::prog_t      progress
);
    import mmsm_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eop;
        hit_t       mask;
    } pay_t;

    logic  valid_reg;
    pay_t  pay_reg;
    pay_t  pay_next;
    prog_t prog_reg;
    prog_t prog_next;
    prog_t p_eff;
    prog_t p_inc;
    logic  hit;
    logic  step;

    assign step = en && stage_in.valid;

    always_comb
    begin
        // out-of-range progress is taken as zero
        p_eff     = (prog_reg >= len) ? '0 : prog_reg;
        p_inc     = p_eff + prog_t'(1);
        hit       = 1'b0;
        prog_next = prog_reg;
        if (len != '0) begin
            if (stage_in.data == pattern[p_eff]) begin
                if (p_inc == len) begin
                    hit       = 1'b1;
                    prog_next = '0;
                end
                else begin
                    prog_next = p_inc;
                end
            end
            else if (stage_in.data == pattern[0]) begin
                prog_next = prog_t'(1);
            end
            else begin
                prog_next = '0;
            end
        end
    end

    always_comb
    begin
        pay_next.data = stage_in.data;
        pay_next.eop  = stage_in.eop;
        pay_next.mask = stage_in.mask | (hit ? hit_bit : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            prog_reg  <= '0;
        end
        else begin
            if (en) begin
                valid_reg <= stage_in.valid;
            end
            if (step) begin
                prog_reg <= prog_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            pay_reg <= pay_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.data  = pay_reg.data;
    assign stage_out.eop   = pay_reg.eop;
    assign stage_out.mask  = pay_reg.mask;
    assign progress        = prog_reg;

endmodule

`default_nettype wire

// File: rtl/multi_marker_stream_matcher_top.sv
`default_nettype none

// Multi-marker stream matcher. Scans a byte stream for seven fixed marker
// strings and returns one item per input byte: hit_mask has bit k set when
// marker k completed on that byte, packet_end copies end_of_packet. Each
// marker keeps a progress count; on a mismatch the count restarts at 1 if
// the byte equals the marker's first character, else at 0, so overlapping
// occurrences that need a deeper fallback are not reported. Progress runs
// across packet boundaries. The matcher is a chain of NUM_MARKERS cells; a
// byte enters cell 0 and moves one cell per cycle while the chain is not
// held, each cell checking it against its own marker and ORing its hit into
// the travelling mask. Throughput is one byte per cycle unless the chain
// holds. The whole chain advances together, so it holds when the final
// stage has an item that is not taken; in_ready is low only then. No
// clearing pass is needed after reset.
module multi_marker_stream_matcher_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_packet,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [mmsm_pkg::HIT_W-1:0] hit_mask,
    output logic            packet_end
);
    import mmsm_pkg::*;

    stage_t chain [NUM_MARKERS+1];
    prog_t  progress [NUM_MARKERS];
    logic   en;

    // chain moves whenever the last stage is empty or being drained
    assign en       = !chain[NUM_MARKERS].valid || out_ready;
    assign in_ready = en;

    assign chain[0].valid = in_valid;
    assign chain[0].data  = data_byte;
    assign chain[0].eop   = end_of_packet;
    assign chain[0].mask  = '0;

    for (genvar k = 0; k < NUM_MARKERS; k++) begin : g_cell
        // markers beyond the mask width still run but their hit is dropped
        localparam hit_t  BIT = (k < HIT_W) ? (hit_t'(1) << k) : '0;
        localparam prog_t LEN = prog_t'(marker_len(k));
        localparam row_t  ROW = marker_row(k);

        mmsm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .pattern  (ROW),
            .len      (LEN),
            .hit_bit  (BIT),
            .stage_in (chain[k]),
            .stage_out(chain[k+1]),
            .progress (progress[k])
        );
    end

    assign out_valid  = chain[NUM_MARKERS].valid;
    assign hit_mask   = chain[NUM_MARKERS].mask;
    assign packet_end = chain[NUM_MARKERS].eop;

`ifndef SYNTH
    // a held result must freeze the input side too
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

    // chain hold keeps the result in place
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hit_mask)
                                        && $stable(packet_end)))
        else $error("stalled result changed");

    for (genvar k = 0; k < NUM_MARKERS; k++) begin : g_chk
        // progress never reaches the marker length (completion resets it)
        a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
            (marker_len(k) == 0) || (int'(progress[k]) < marker_len(k)))
            else $error("marker progress out of range");
    end
`endif

endmodule

`default_nettype wire
